// File: hw/rtl/klec_pkg.sv
// shared types and constants for the keyed lru entry cache
package klec_pkg;

    // default geometry
    localparam int POOL_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF     = 16;

    // fixed result field widths
    localparam int OUT_SLOT_W  = 8;
    localparam int OUT_COUNT_W = 9;

    // operation codes
    typedef enum logic [2:0] {
        K_LOOKUP  = 3'd0,
        K_ALLOC   = 3'd1,
        K_RMKEY   = 3'd2,
        K_RMUSER  = 3'd3,
        K_DROPALL = 3'd4
    } t_kind;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SDEC,
        S_UPD,
        S_UDEC,
        S_DONE
    } t_state;

    // rank update pass flavor
    typedef enum logic [1:0] {
        M_PROMOTE,
        M_INSERT,
        M_REMOVE
    } t_mode;

    // result fields other than the victim keys
    typedef struct packed {
        logic                   status;
        logic                   hit;
        logic [OUT_SLOT_W-1:0]  slot;
        logic                   evicted;
        logic [OUT_COUNT_W-1:0] removed;
        logic [OUT_COUNT_W-1:0] occ;
    } t_res;

endpackage

// File: hw/rtl/keyed_lru_entry_cache.sv
// keyed lru entry cache: sequencer around one key and rank memory
// sequence: one scan over every entry, then one update pass over every entry per entry
// changed (lookup/allocate hit, allocate, each removed key), then the result register
// throughput: one operation at a time; the memory passes at one entry per cycle set it
// reject and drop-all skip the memory passes; the result register frees the next accept
// reset (synchronous, active low) clears all valid bits and the entry count at once
module keyed_lru_entry_cache
    import klec_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [2:0]             i_kind,
    input  logic [KEY_BITS-1:0]    i_user_key,
    input  logic [KEY_BITS-1:0]    i_contest_key,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_status,
    output logic                   o_hit,
    output logic [OUT_SLOT_W-1:0]  o_slot,
    output logic                   o_evicted,
    output logic [KEY_BITS-1:0]    o_victim_user,
    output logic [KEY_BITS-1:0]    o_victim_contest,
    output logic [OUT_COUNT_W-1:0] o_removed_count,
    output logic [OUT_COUNT_W-1:0] o_occupancy
);

    localparam int SLOT_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0] user;
        logic [KEY_BITS-1:0] contest;
        logic [SLOT_W-1:0]   rank;
    } t_entry;

    // entry store
    t_entry mem [POOL_ENTRIES];
    t_entry r_rdata;

    t_state r_state, n_state;
    t_kind  r_kind;
    t_mode  r_mode;
    logic [KEY_BITS-1:0]     r_user, r_contest;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_pv;
    logic [SLOT_W-1:0]       r_pidx;
    logic [POOL_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_removed;
    logic                    r_mfound, r_ffound, r_nfound;
    logic [SLOT_W-1:0]       r_midx, r_mrank, r_fidx, r_vidx, r_nidx, r_nrank;
    logic [SLOT_W-1:0]       r_sidx, r_rank;
    logic [KEY_BITS-1:0]     r_vuser, r_vcont;
    t_res                    r_res, r_out;
    logic [KEY_BITS-1:0]     r_res_vu, r_res_vc, r_out_vu, r_out_vc;
    logic                    r_ovalid;

    logic              accept, reject, issue, last, out_free, go_upd;
    logic              cur_v, key_match, w_en;
    logic [SLOT_W-1:0] lru_rank, new_rank;
    t_entry            w_data;
    t_res              res_init, out_next;

    // handshake and pass control
    always_comb begin
        accept   = i_valid && (r_state == S_IDLE);
        reject   = (i_kind > 3'(K_DROPALL))
                || ((i_kind != 3'(K_DROPALL)) && (i_user_key == '0))
                || (((i_kind == 3'(K_LOOKUP)) || (i_kind == 3'(K_RMKEY)))
                    && (i_contest_key == '0));
        issue    = ((r_state == S_SCAN) || (r_state == S_UPD))
                && (r_cnt < CNT_W'(POOL_ENTRIES));
        last     = r_pv && (r_pidx == SLOT_W'(POOL_ENTRIES - 1));
        out_free = !r_ovalid || !i_stall;
        go_upd   = (r_kind == K_ALLOC) || r_mfound;
        cur_v    = r_valid[r_pidx];
        lru_rank = SLOT_W'(r_count - CNT_W'(1));
        key_match = cur_v && (r_rdata.user == r_user)
                 && ((r_kind == K_RMUSER) || (r_rdata.contest == r_contest));
        // result seed at accept
        res_init        = '0;
        res_init.status = reject;
        if (!reject && (i_kind == 3'(K_DROPALL))) res_init.removed = OUT_COUNT_W'(r_count);
        // outgoing beat with the current occupancy
        out_next     = r_res;
        out_next.occ = OUT_COUNT_W'(r_count);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                n_state = (reject || (i_kind == 3'(K_DROPALL))) ? S_DONE : S_SCAN;
            end
            S_SCAN: if (last) n_state = S_SDEC;
            S_SDEC: n_state = go_upd ? S_UPD : S_DONE;
            S_UPD:  if (last) n_state = S_UDEC;
            S_UDEC: n_state = ((r_kind == K_RMUSER) && r_nfound) ? S_UPD : S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // rank rewrite during the update pass
    always_comb begin
        w_en     = 1'b0;
        w_data   = r_rdata;
        new_rank = r_rdata.rank;
        if (r_state == S_UPD && r_pv) begin
            case (r_mode)
                M_PROMOTE: begin
                    if (r_pidx == r_sidx) begin
                        new_rank = '0;
                    end else if (r_rdata.rank < r_rank) begin
                        new_rank = r_rdata.rank + SLOT_W'(1);
                    end
                    w_en = cur_v;
                end
                M_INSERT: begin
                    if (r_pidx == r_sidx) begin
                        w_data.user    = r_user;
                        w_data.contest = r_contest;
                        new_rank       = '0;
                    end else begin
                        new_rank = r_rdata.rank + SLOT_W'(1);
                    end
                    w_en = cur_v;
                end
                default: begin
                    if (r_rdata.rank > r_rank) new_rank = r_rdata.rank - SLOT_W'(1);
                    w_en = cur_v;
                end
            endcase
        end
        w_data.rank = new_rank;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_cnt[SLOT_W-1:0]];
        if (w_en) mem[r_pidx] <= w_data;
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_count  <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            r_pidx  <= r_cnt[SLOT_W-1:0];
            if (issue) r_cnt <= r_cnt + CNT_W'(1);

            // result register
            if (r_state == S_DONE && out_free) begin
                r_out       <= out_next;
                r_out_vu    <= r_res_vu;
                r_out_vc    <= r_res_vc;
                r_ovalid    <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_kind    <= t_kind'(i_kind);
                    r_user    <= i_user_key;
                    r_contest <= i_contest_key;
                    r_cnt     <= '0;
                    r_mfound  <= 1'b0;
                    r_ffound  <= 1'b0;
                    r_nfound  <= 1'b0;
                    r_vidx    <= '0;
                    r_vuser   <= '0;
                    r_vcont   <= '0;
                    r_removed <= '0;
                    r_res     <= res_init;
                    r_res_vu  <= '0;
                    r_res_vc  <= '0;
                    if (!reject && (i_kind == 3'(K_DROPALL))) begin
                        r_valid <= '0;
                        r_count <= '0;
                    end
                end
                S_SCAN: if (r_pv) begin
                    if (key_match && !r_mfound) begin
                        r_mfound <= 1'b1;
                        r_midx   <= r_pidx;
                        r_mrank  <= r_rdata.rank;
                    end
                    if (!cur_v && !r_ffound) begin
                        r_ffound <= 1'b1;
                        r_fidx   <= r_pidx;
                    end
                    if (cur_v && r_rdata.rank == lru_rank) begin
                        r_vidx  <= r_pidx;
                        r_vuser <= r_rdata.user;
                        r_vcont <= r_rdata.contest;
                    end
                end
                S_SDEC: begin
                    r_cnt <= '0;
                    if (r_mfound) begin
                        r_sidx    <= r_midx;
                        r_rank    <= r_mrank;
                        r_res.hit <= 1'b1;
                        if (r_kind != K_RMUSER) r_res.slot <= OUT_SLOT_W'(r_midx);
                        if (r_kind == K_LOOKUP || r_kind == K_ALLOC) begin
                            r_mode <= M_PROMOTE;
                        end else begin
                            r_mode          <= M_REMOVE;
                            r_valid[r_midx] <= 1'b0;
                            r_count         <= r_count - CNT_W'(1);
                            r_removed       <= CNT_W'(1);
                            r_res.removed   <= OUT_COUNT_W'(1);
                        end
                    end else if (r_kind == K_ALLOC) begin
                        r_mode <= M_INSERT;
                        if (r_count == CNT_W'(POOL_ENTRIES)) begin
                            // full: reuse the least recent slot
                            r_sidx        <= r_vidx;
                            r_res.slot    <= OUT_SLOT_W'(r_vidx);
                            r_res.evicted <= 1'b1;
                            r_res.removed <= OUT_COUNT_W'(1);
                            r_res_vu      <= r_vuser;
                            r_res_vc      <= r_vcont;
                        end else begin
                            r_sidx          <= r_fidx;
                            r_res.slot      <= OUT_SLOT_W'(r_fidx);
                            r_valid[r_fidx] <= 1'b1;
                            r_count         <= r_count + CNT_W'(1);
                        end
                    end
                end
                S_UPD: if (r_pv && r_mode == M_REMOVE && r_kind == K_RMUSER) begin
                    // look for the next key of this user while ranks close up
                    if (key_match && !r_nfound) begin
                        r_nfound <= 1'b1;
                        r_nidx   <= r_pidx;
                        r_nrank  <= new_rank;
                    end
                end
                S_UDEC: if (r_kind == K_RMUSER && r_nfound) begin
                    r_cnt           <= '0;
                    r_nfound        <= 1'b0;
                    r_sidx          <= r_nidx;
                    r_rank          <= r_nrank;
                    r_valid[r_nidx] <= 1'b0;
                    r_count         <= r_count - CNT_W'(1);
                    r_removed       <= r_removed + CNT_W'(1);
                    r_res.removed   <= OUT_COUNT_W'(r_removed + CNT_W'(1));
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // port drive
    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_out.status;
    assign o_hit            = r_out.hit;
    assign o_slot           = r_out.slot;
    assign o_evicted        = r_out.evicted;
    assign o_victim_user    = r_out_vu;
    assign o_victim_contest = r_out_vc;
    assign o_removed_count  = r_out.removed;
    assign o_occupancy      = r_out.occ;

    // checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("entry count disagrees with valid bits");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_hit && !o_evicted && (o_removed_count == '0))
        else $error("rejected beat carries results");

    a_evict_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_hit && (o_removed_count == OUT_COUNT_W'(1)))
        else $error("eviction beat inconsistent");

    a_pass_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pv) |-> (r_pidx == '0))
        else $error("memory pass did not start at entry zero");

endmodule
